>>> hw/rtl/miir_pkg.sv
`timescale 1ns / 1ps

package miir_pkg;

    // Fixed-point formats: samples Q16.16, coefficients Q4.28.
    localparam int FRAC_BITS  = 28;
    localparam int GAIN_BITS  = 29;
    localparam int COEF_BITS  = 32;
    localparam int CHAN_BITS  = 5;
    localparam int PORT_BITS  = 32;
    localparam int ADDR_BITS  = 5;
    localparam int ORDER_BITS = 3;
    localparam int HIST_TAPS  = 4;

    // Nine products per item: five feedforward taps, then four feedback taps.
    localparam int MAC_STEPS  = 9;
    localparam int STEP_BITS  = 4;

    localparam logic [ORDER_BITS-1:0] ORDER_MIN = 3'd1;
    localparam logic [ORDER_BITS-1:0] ORDER_MAX = 3'd4;

    localparam logic [ORDER_BITS-1:0] ORDER_RESET = 3'd1;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 29'd134217728;

    typedef enum logic [2:0] {
        REG_ORDER  = 3'd0,
        REG_GAIN   = 3'd1,
        REG_FB_ONE = 3'd2,
        REG_FB_TWO = 3'd3,
        REG_FB_THR = 3'd4,
        REG_FB_FOU = 3'd5
    } t_reg_idx;

    // Binomial coefficients C(n, k), rows indexed by the filter order.
    localparam logic [2:0] BINOM [0:4][0:4] = '{
        '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd2, 3'd1, 3'd0, 3'd0},
        '{3'd1, 3'd3, 3'd3, 3'd1, 3'd0},
        '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1}
    };

    // Gain times a small binomial, built from shifts and one add.
    function automatic logic [COEF_BITS-1:0] scale_gain(
        input logic [GAIN_BITS-1:0] gain,
        input logic [2:0]           mult
    );
        logic [COEF_BITS-1:0] g;
        logic [COEF_BITS-1:0] res;
        g = COEF_BITS'(gain);
        case (mult)
            3'd1:    res = g;
            3'd2:    res = g << 1;
            3'd3:    res = g + (g << 1);
            3'd4:    res = g << 2;
            3'd6:    res = (g << 2) + (g << 1);
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

>>> hw/rtl/multichannel_iir_lowpass.sv
`timescale 1ns / 1ps
// Flow: an item goes from the input skid register through the S_MAC steps and S_DONE into
// the output register; a channel number at or above CHANNELS goes straight to S_DONE.
// The engine works on one item at a time, since the nine taps share one multiplier, and
// S_DONE does rounding, saturation and history write-back; the skid register holds the next.
// Reset (synchronous, active low) restores the configuration registers, clears every
// channel's primed bit and empties the pipeline; the history memories are not cleared.

module multichannel_iir_lowpass #(
    parameter int CHANNELS    = 32,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Input channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [miir_pkg::CHAN_BITS-1:0]      i_channel,
    input  logic signed [miir_pkg::PORT_BITS-1:0] i_sample_in,

    // Output channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [miir_pkg::CHAN_BITS-1:0]      o_channel_out,
    output logic signed [miir_pkg::PORT_BITS-1:0] o_sample_out,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [miir_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // History samples are kept at the saturated sample width, which never exceeds 32 bits.
    localparam int HB    = (SAMPLE_BITS > 32) ? 32 : SAMPLE_BITS;
    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROW_W = miir_pkg::HIST_TAPS * HB;
    // Coefficient operand is 33 bits signed so that both the unsigned feedforward taps
    // and the negated feedback taps fit. Nine products need four guard bits.
    localparam int CW    = miir_pkg::COEF_BITS + 1;
    localparam int PW    = CW + HB;
    localparam int AW    = PW + 4;
    localparam int QW    = AW - miir_pkg::FRAC_BITS;

    localparam logic signed [63:0] HMAX = (64'sd1 <<< (HB - 1)) - 64'sd1;
    localparam logic signed [63:0] HMIN = -HMAX - 64'sd1;
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(64'sd1 <<< (miir_pkg::FRAC_BITS - 1));
    localparam logic [miir_pkg::STEP_BITS-1:0] LAST_STEP =
        miir_pkg::STEP_BITS'(miir_pkg::MAC_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MAC  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    function automatic logic [HB-1:0] sat_h(input logic signed [63:0] v);
        logic [HB-1:0] res;
        if (v > HMAX) begin
            res = HB'(HMAX);
        end else if (v < HMIN) begin
            res = HB'(HMIN);
        end else begin
            res = HB'(v);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. Writes must only arrive while the block is idle;
    // the block does not enforce this. The datapath reads them directly.
    // ------------------------------------------------------------------
    logic [miir_pkg::ORDER_BITS-1:0]      r_order;
    logic [miir_pkg::GAIN_BITS-1:0]       r_gain;
    logic signed [miir_pkg::COEF_BITS-1:0] r_fb [miir_pkg::HIST_TAPS];
    logic                                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= miir_pkg::ORDER_RESET;
            r_gain  <= miir_pkg::GAIN_RESET;
            for (int k = 0; k < miir_pkg::HIST_TAPS; k++) begin
                r_fb[k] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                miir_pkg::REG_ORDER:  r_order <= pwdata[miir_pkg::ORDER_BITS-1:0];
                miir_pkg::REG_GAIN:   r_gain  <= pwdata[miir_pkg::GAIN_BITS-1:0];
                miir_pkg::REG_FB_ONE: r_fb[0] <= pwdata;
                miir_pkg::REG_FB_TWO: r_fb[1] <= pwdata;
                miir_pkg::REG_FB_THR: r_fb[2] <= pwdata;
                miir_pkg::REG_FB_FOU: r_fb[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            miir_pkg::REG_ORDER:  prdata = 32'(r_order);
            miir_pkg::REG_GAIN:   prdata = 32'(r_gain);
            miir_pkg::REG_FB_ONE: prdata = r_fb[0];
            miir_pkg::REG_FB_TWO: prdata = r_fb[1];
            miir_pkg::REG_FB_THR: prdata = r_fb[2];
            miir_pkg::REG_FB_FOU: prdata = r_fb[3];
            default:              prdata = '0;
        endcase
    end

    // Order zero runs as order one, anything above four as order four.
    logic [miir_pkg::ORDER_BITS-1:0] n_eff;
    always_comb begin
        if (r_order < miir_pkg::ORDER_MIN) begin
            n_eff = miir_pkg::ORDER_MIN;
        end else if (r_order > miir_pkg::ORDER_MAX) begin
            n_eff = miir_pkg::ORDER_MAX;
        end else begin
            n_eff = r_order;
        end
    end

    // ------------------------------------------------------------------
    // Input skid register. It takes a new item while the engine is busy
    // with the previous one; upstream waits while an item is held here,
    // until the engine starts it. The sample is saturated on the way in.
    // ------------------------------------------------------------------
    logic                          r_buf_vld;
    logic [miir_pkg::CHAN_BITS-1:0] r_buf_ch;
    logic [HB-1:0]                 r_buf_x;
    logic                          in_take;
    logic                          start;

    assign o_stall = r_buf_vld;
    assign in_take = i_valid && !r_buf_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_buf_vld <= 1'b1;
            end else if (start) begin
                r_buf_vld <= 1'b0;
            end
        end
        if (in_take) begin
            r_buf_ch <= i_channel;
            r_buf_x  <= sat_h(64'(i_sample_in));
        end
    end

    // ------------------------------------------------------------------
    // Engine state.
    // ------------------------------------------------------------------
    t_state                        r_state;
    t_state                        n_state;
    logic [miir_pkg::STEP_BITS-1:0] r_step;
    logic [miir_pkg::CHAN_BITS-1:0] r_ch;
    logic [CH_AW-1:0]              r_addr;
    logic [HB-1:0]                 r_x;
    logic                          r_oor;
    logic                          r_first;
    logic                          r_fwd;
    logic [CHANNELS-1:0]           r_primed;
    logic signed [PW-1:0]          r_prod;
    logic signed [AW-1:0]          r_acc;

    logic                          r_o_vld;
    logic [miir_pkg::CHAN_BITS-1:0] r_o_ch;
    logic signed [miir_pkg::PORT_BITS-1:0] r_o_y;

    logic                          leave;
    logic                          buf_oor;
    logic [CH_AW-1:0]              rd_addr;
    logic                          wr_en;

    // The engine may hand its result over when the output register is empty
    // or is being emptied in this same cycle.
    assign leave   = (r_state == S_DONE) && (!r_o_vld || !i_stall);
    assign start   = r_buf_vld && ((r_state == S_IDLE) || leave);
    assign buf_oor = (32'(r_buf_ch) >= 32'(CHANNELS));
    assign rd_addr = CH_AW'(r_buf_ch);
    assign wr_en   = leave && !r_oor;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = buf_oor ? S_DONE : S_MAC;
                end
            end
            S_MAC: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (start) begin
                    n_state = buf_oor ? S_DONE : S_MAC;
                end else if (leave) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // History memories: one row per channel, four samples to a row, the
    // newest in the lowest slot. A row is read when the item starts and
    // written back in the item's last cycle.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] in_mem  [CHANNELS];
    logic [ROW_W-1:0] out_mem [CHANNELS];
    logic [ROW_W-1:0] r_in_rd;
    logic [ROW_W-1:0] r_out_rd;
    logic [ROW_W-1:0] r_wb_in;
    logic [ROW_W-1:0] r_wb_out;
    logic [ROW_W-1:0] n_wb_in;
    logic [ROW_W-1:0] n_wb_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            in_mem[r_addr]  <= n_wb_in;
            out_mem[r_addr] <= n_wb_out;
            r_wb_in         <= n_wb_in;
            r_wb_out        <= n_wb_out;
        end
        if (start && !buf_oor) begin
            r_in_rd  <= in_mem[rd_addr];
            r_out_rd <= out_mem[rd_addr];
        end
    end

    // A row read in the same cycle as its own write-back would see stale data,
    // so in that case the written rows are forwarded from r_wb_in / r_wb_out.
    // A channel's first item ignores the memory and sees its own sample in
    // every history slot.
    logic [ROW_W-1:0] eff_in_row;
    logic [ROW_W-1:0] eff_out_row;

    always_comb begin
        if (r_first) begin
            eff_in_row  = {miir_pkg::HIST_TAPS{r_x}};
            eff_out_row = {miir_pkg::HIST_TAPS{r_x}};
        end else if (r_fwd) begin
            eff_in_row  = r_wb_in;
            eff_out_row = r_wb_out;
        end else begin
            eff_in_row  = r_in_rd;
            eff_out_row = r_out_rd;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier. Steps 0 to 4 are the feedforward taps (current
    // sample, then x[n-1]..x[n-4]); steps 5 to 8 are the negated feedback
    // taps on y[n-1]..y[n-4], zero above the filter order.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] mul_coef;
    logic signed [HB-1:0] mul_tap;

    function automatic logic signed [CW-1:0] ff_coef(input logic [2:0] k,
                                                     input logic [2:0] order,
                                                     input logic [miir_pkg::GAIN_BITS-1:0] g);
        return signed'({1'b0, miir_pkg::scale_gain(g, miir_pkg::BINOM[order][k])});
    endfunction

    function automatic logic signed [CW-1:0] fb_coef(input logic [2:0] k,
                                                     input logic [2:0] order,
                                                     input logic signed [31:0] b);
        logic signed [CW-1:0] res;
        if (k < order) begin
            res = -CW'(b);
        end else begin
            res = '0;
        end
        return res;
    endfunction

    always_comb begin
        case (r_step)
            4'd0: begin
                mul_coef = ff_coef(3'd0, n_eff, r_gain);
                mul_tap  = signed'(r_x);
            end
            4'd1: begin
                mul_coef = ff_coef(3'd1, n_eff, r_gain);
                mul_tap  = signed'(eff_in_row[0*HB +: HB]);
            end
            4'd2: begin
                mul_coef = ff_coef(3'd2, n_eff, r_gain);
                mul_tap  = signed'(eff_in_row[1*HB +: HB]);
            end
            4'd3: begin
                mul_coef = ff_coef(3'd3, n_eff, r_gain);
                mul_tap  = signed'(eff_in_row[2*HB +: HB]);
            end
            4'd4: begin
                mul_coef = ff_coef(3'd4, n_eff, r_gain);
                mul_tap  = signed'(eff_in_row[3*HB +: HB]);
            end
            4'd5: begin
                mul_coef = fb_coef(3'd0, n_eff, r_fb[0]);
                mul_tap  = signed'(eff_out_row[0*HB +: HB]);
            end
            4'd6: begin
                mul_coef = fb_coef(3'd1, n_eff, r_fb[1]);
                mul_tap  = signed'(eff_out_row[1*HB +: HB]);
            end
            4'd7: begin
                mul_coef = fb_coef(3'd2, n_eff, r_fb[2]);
                mul_tap  = signed'(eff_out_row[2*HB +: HB]);
            end
            4'd8: begin
                mul_coef = fb_coef(3'd3, n_eff, r_fb[3]);
                mul_tap  = signed'(eff_out_row[3*HB +: HB]);
            end
            default: begin
                mul_coef = '0;
                mul_tap  = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Final step: the last product joins the sum, which already carries the
    // rounding half, then the Q4.28 fraction is dropped (floor) and the
    // result saturates to the sample width.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] final_sum;
    logic signed [QW-1:0] final_q;
    logic [HB-1:0]        done_y;

    assign final_sum = r_acc + AW'(r_prod);
    assign final_q   = final_sum[AW-1:miir_pkg::FRAC_BITS];
    assign done_y    = r_oor ? '0 : sat_h(64'(final_q));
    assign n_wb_in   = {eff_in_row[(miir_pkg::HIST_TAPS-1)*HB-1:0], r_x};
    assign n_wb_out  = {eff_out_row[(miir_pkg::HIST_TAPS-1)*HB-1:0], done_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_primed <= '0;
            r_fwd    <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                // The primed bit is set as the item starts, so a following item
                // of the same channel never primes it again.
                r_fwd <= wr_en && (r_addr == rd_addr);
                if (!buf_oor) begin
                    r_primed[rd_addr] <= 1'b1;
                end
            end
            if (leave) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end

        if (start) begin
            r_ch    <= r_buf_ch;
            r_addr  <= rd_addr;
            r_x     <= r_buf_x;
            r_oor   <= buf_oor;
            r_first <= buf_oor ? 1'b0 : !r_primed[rd_addr];
            r_step  <= '0;
            r_acc   <= ROUND_HALF;
        end else if (r_state == S_MAC) begin
            r_step <= r_step + 1'b1;
            if (r_step != '0) begin
                r_acc <= r_acc + AW'(r_prod);
            end
        end
        if (r_state == S_MAC) begin
            r_prod <= PW'(mul_coef) * PW'(mul_tap);
        end

        if (leave) begin
            r_o_ch <= r_ch;
            r_o_y  <= miir_pkg::PORT_BITS'(signed'(done_y));
        end
    end

    assign o_valid       = r_o_vld;
    assign o_channel_out = r_o_ch;
    assign o_sample_out  = r_o_y;

endmodule

>>> hw/rtl/miir_checker.sv
`timescale 1ns / 1ps

module miir_checker #(
    parameter int CHANNELS    = 32,
    parameter int SAMPLE_BITS = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [4:0]  o_channel_out,
    input logic [31:0] o_sample_out
);

    localparam int HB = (SAMPLE_BITS > 32) ? 32 : SAMPLE_BITS;
    localparam logic signed [63:0] HMAX = (64'sd1 <<< (HB - 1)) - 64'sd1;
    localparam logic signed [63:0] HMIN = -HMAX - 64'sd1;

    // A stalled result holds its place and its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_channel_out) && $stable(o_sample_out))
        else $error("result changed while stalled");

    // The skid register fills on every accepted item, so stall follows.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after an accepted item");

    // Channels without history give a zero result.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (32'(o_channel_out) >= 32'(CHANNELS)) |-> o_sample_out == '0)
        else $error("nonzero result for a channel without history");

    // Results stay inside the saturated sample range.
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (64'($signed(o_sample_out)) <= HMAX) &&
                    (64'($signed(o_sample_out)) >= HMIN))
        else $error("result outside the saturated range");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind multichannel_iir_lowpass miir_checker #(
    .CHANNELS(CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
) u_miir_checker (.*);

>>> tb/multichannel_iir_lowpass_tb.sv
`timescale 1ns / 1ps

module multichannel_iir_lowpass_tb;

    localparam int NUM_CHANNELS  = 32;
    localparam int IDLE_PERCENT  = 16;
    // Margin to wait after the last owed result, so that the block has settled.
    localparam int DRAIN_CYCLES  = 16;
    localparam int REPORT_LIMIT  = 10;
    // Generous cap: a slow but correct run needs well under a quarter of this.
    localparam int WATCHDOG_NS   = 2000000;
    // Addresses past the register list; writes there must change nothing.
    localparam int REG_SPARE_LOW  = 6;
    localparam int REG_SPARE_HIGH = 7;

    // Wide accumulator constants for the exact nine-product sum.
    localparam logic signed [79:0] ROUND_HALF = 80'sd134217728;
    localparam logic signed [79:0] SAMPLE_MAX = 80'sd2147483647;
    localparam logic signed [79:0] SAMPLE_MIN = -80'sd2147483648;

    typedef struct packed {
        logic [miir_pkg::CHAN_BITS-1:0]        channel;
        logic signed [miir_pkg::PORT_BITS-1:0] sample;
    } t_filtered;

    // Block ports. Every input starts at a known value.
    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_valid = 1'b0;
    logic                                  o_stall;
    logic [miir_pkg::CHAN_BITS-1:0]        i_channel = '0;
    logic signed [miir_pkg::PORT_BITS-1:0] i_sample_in = '0;
    logic                                  o_valid;
    logic                                  i_stall = 1'b0;
    logic [miir_pkg::CHAN_BITS-1:0]        o_channel_out;
    logic signed [miir_pkg::PORT_BITS-1:0] o_sample_out;
    logic                                  psel = 1'b0;
    logic                                  penable = 1'b0;
    logic                                  pwrite = 1'b0;
    logic [miir_pkg::ADDR_BITS-1:0]        paddr = '0;
    logic [31:0]                           pwdata = '0;
    logic [31:0]                           prdata;
    logic                                  pready;

    // Our own copy of the configuration and of each channel's history.
    logic [miir_pkg::ORDER_BITS-1:0]       cfg_order = miir_pkg::ORDER_RESET;
    logic [miir_pkg::GAIN_BITS-1:0]        cfg_gain = miir_pkg::GAIN_RESET;
    logic signed [miir_pkg::COEF_BITS-1:0] cfg_feedback [miir_pkg::HIST_TAPS] =
        '{default: '0};
    logic signed [miir_pkg::PORT_BITS-1:0] past_inputs  [NUM_CHANNELS][miir_pkg::HIST_TAPS];
    logic signed [miir_pkg::PORT_BITS-1:0] past_outputs [NUM_CHANNELS][miir_pkg::HIST_TAPS];
    bit                                    channel_seen [NUM_CHANNELS];

    // Filtered samples still owed by the block, oldest first.
    t_filtered pending_outputs [$];
    int        fail_count = 0;
    // When set, neither side idles or stalls.
    bit        quiet = 1'b0;

    multichannel_iir_lowpass i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_channel     (i_channel),
        .i_sample_in   (i_sample_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_channel_out (o_channel_out),
        .o_sample_out  (o_sample_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // A 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    function automatic int binomial(input int n, input int k);
        int c;
        int i;
        c = 1;
        for (i = 0; i < k; i++) begin
            c = c * (n - i) / (i + 1);
        end
        return c;
    endfunction

    // Computes one filtered sample and advances the channel's history. The sum of all
    // nine products is kept exact, rounded half up at the Q4.28 point, then saturated.
    function automatic logic signed [miir_pkg::PORT_BITS-1:0] filter_step(
        input logic [miir_pkg::CHAN_BITS-1:0]        ch,
        input logic signed [miir_pkg::PORT_BITS-1:0] x
    );
        logic signed [79:0] acc;
        logic signed [79:0] gain;
        logic signed [79:0] coef;
        logic signed [79:0] hist;
        int order;
        int k;
        order = int'(cfg_order);
        if (order < int'(miir_pkg::ORDER_MIN)) order = int'(miir_pkg::ORDER_MIN);
        if (order > int'(miir_pkg::ORDER_MAX)) order = int'(miir_pkg::ORDER_MAX);
        // The first sample a channel sees fills its whole history.
        if (!channel_seen[ch]) begin
            for (k = 0; k < miir_pkg::HIST_TAPS; k++) begin
                past_inputs[ch][k]  = x;
                past_outputs[ch][k] = x;
            end
            channel_seen[ch] = 1'b1;
        end
        gain = $signed({51'b0, cfg_gain});
        acc = '0;
        for (k = 0; k <= miir_pkg::HIST_TAPS; k++) begin
            if (k == 0) begin
                hist = 80'(x);
            end else begin
                hist = 80'(past_inputs[ch][k-1]);
            end
            coef = 80'(binomial(order, k));
            acc += gain * coef * hist;
        end
        // Feedback taps above the order count as zero whatever the register holds.
        for (k = 0; k < order; k++) begin
            coef = 80'(cfg_feedback[k]);
            hist = 80'(past_outputs[ch][k]);
            acc -= coef * hist;
        end
        acc = (acc + ROUND_HALF) >>> miir_pkg::FRAC_BITS;
        if (acc > SAMPLE_MAX) begin
            acc = SAMPLE_MAX;
        end else if (acc < SAMPLE_MIN) begin
            acc = SAMPLE_MIN;
        end
        for (k = miir_pkg::HIST_TAPS - 1; k > 0; k--) begin
            past_inputs[ch][k]  = past_inputs[ch][k-1];
            past_outputs[ch][k] = past_outputs[ch][k-1];
        end
        past_inputs[ch][0]  = x;
        past_outputs[ch][0] = acc[miir_pkg::PORT_BITS-1:0];
        return acc[miir_pkg::PORT_BITS-1:0];
    endfunction

    function automatic logic [31:0] register_value(input int index);
        case (index)
            miir_pkg::REG_ORDER:  return 32'(cfg_order);
            miir_pkg::REG_GAIN:   return 32'(cfg_gain);
            miir_pkg::REG_FB_ONE, miir_pkg::REG_FB_TWO, miir_pkg::REG_FB_THR,
            miir_pkg::REG_FB_FOU:
                return cfg_feedback[index - miir_pkg::REG_FB_ONE];
            default:    return '0;
        endcase
    endfunction

    // One write: a setup phase, then an access phase that completes when pready is high.
    task automatic write_reg(input int index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= miir_pkg::ADDR_BITS'(4 * index);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (index)
            miir_pkg::REG_ORDER: cfg_order = value[miir_pkg::ORDER_BITS-1:0];
            miir_pkg::REG_GAIN:  cfg_gain = value[miir_pkg::GAIN_BITS-1:0];
            miir_pkg::REG_FB_ONE, miir_pkg::REG_FB_TWO, miir_pkg::REG_FB_THR,
            miir_pkg::REG_FB_FOU:
                cfg_feedback[index - miir_pkg::REG_FB_ONE] = value;
            default: ;
        endcase
    endtask

    task automatic read_reg(input int index, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= miir_pkg::ADDR_BITS'(4 * index);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic verify_registers();
        logic [31:0] got;
        int idx;
        for (idx = miir_pkg::REG_ORDER; idx <= miir_pkg::REG_FB_FOU; idx++) begin
            read_reg(idx, got);
            if (got !== register_value(idx)) begin
                note_failure($sformatf("register %0d read: expected %h, got %h",
                                       idx, register_value(idx), got));
            end
        end
    endtask

    // Lowers valid, waits for every owed sample, then lets the pipeline settle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Presents one item and holds it until the block takes it. Valid stays high on
    // return so that back-to-back items follow without a gap.
    task automatic send_item(input logic [miir_pkg::CHAN_BITS-1:0] ch,
                             input logic signed [miir_pkg::PORT_BITS-1:0] smp);
        t_filtered owed;
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_channel   <= ch;
        i_sample_in <= smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        owed.channel = ch;
        owed.sample  = filter_step(ch, smp);
        pending_outputs.push_back(owed);
    endtask

    task automatic apply_filter(input logic [miir_pkg::ORDER_BITS-1:0] order,
                                input logic [miir_pkg::GAIN_BITS-1:0] gain,
                                input logic signed [miir_pkg::COEF_BITS-1:0] fb1,
                                input logic signed [miir_pkg::COEF_BITS-1:0] fb2,
                                input logic signed [miir_pkg::COEF_BITS-1:0] fb3,
                                input logic signed [miir_pkg::COEF_BITS-1:0] fb4);
        wait_drained();
        write_reg(miir_pkg::REG_ORDER, 32'(order));
        write_reg(miir_pkg::REG_GAIN, 32'(gain));
        write_reg(miir_pkg::REG_FB_ONE, fb1);
        write_reg(miir_pkg::REG_FB_TWO, fb2);
        write_reg(miir_pkg::REG_FB_THR, fb3);
        write_reg(miir_pkg::REG_FB_FOU, fb4);
        verify_registers();
    endtask

    // A real low-pass with every pole at 1 - 2^-shift and unity gain at DC. Feedback
    // registers above the order get junk, since the block must ignore them.
    task automatic apply_pole_filter(input int order, input int shift);
        logic signed [miir_pkg::COEF_BITS-1:0] fb [miir_pkg::HIST_TAPS];
        longint mag;
        int k;
        for (k = 1; k <= miir_pkg::HIST_TAPS; k++) begin
            if (k > order) begin
                fb[k-1] = $urandom();
            end else begin
                mag = longint'(binomial(order, k));
                repeat (k) mag *= (longint'(1) << shift) - 1;
                mag = mag << (miir_pkg::FRAC_BITS - shift * k);
                fb[k-1] = miir_pkg::COEF_BITS'((k % 2 == 1) ? -mag : mag);
            end
        end
        apply_filter(miir_pkg::ORDER_BITS'(order),
                     miir_pkg::GAIN_BITS'(1 << (miir_pkg::FRAC_BITS - (shift + 1) * order)),
                     fb[0], fb[1], fb[2], fb[3]);
    endtask

    function automatic logic signed [miir_pkg::PORT_BITS-1:0] pick_sample();
        int roll;
        int v;
        roll = $urandom_range(99);
        if (roll < 3) return 32'h7FFF_FFFF;
        if (roll < 6) return 32'h8000_0000;
        if (roll < 20) return $urandom();
        // Most samples stay within a few hundred units, where the filters behave.
        v = int'($urandom_range(0, 33554431)) - 16777216;
        return miir_pkg::PORT_BITS'(v);
    endfunction

    function automatic logic [miir_pkg::CHAN_BITS-1:0] pick_channel(
        input logic [miir_pkg::CHAN_BITS-1:0] hot
    );
        if ($urandom_range(99) < 80) return hot + miir_pkg::CHAN_BITS'($urandom_range(3));
        return miir_pkg::CHAN_BITS'($urandom());
    endfunction

    // Random items, mostly on a small group of channels so that their histories run deep.
    // At item number pause_at the sender waits until every owed sample has arrived.
    task automatic run_items(input int count, input int pause_at);
        logic [miir_pkg::CHAN_BITS-1:0] hot;
        int n;
        hot = miir_pkg::CHAN_BITS'($urandom());
        for (n = 0; n < count; n++) begin
            if (n == pause_at) wait_drained();
            send_item(pick_channel(hot), pick_sample());
        end
    endtask

    task automatic test_register_defaults();
        verify_registers();
    endtask

    // Reset configuration: half the sum of this and the last sample. Covers the
    // extreme samples, first-sample priming on the lowest and highest channel, and
    // ties in the rounding.
    task automatic test_directed_samples();
        logic [miir_pkg::CHAN_BITS-1:0] chans [10] = '{5'd0, 5'd31, 5'd0, 5'd31, 5'd0,
                                                      5'd31, 5'd0, 5'd31, 5'd15, 5'd15};
        logic signed [miir_pkg::PORT_BITS-1:0] vals [10] = '{
            32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA, 32'hAAAA_5555};
        int n;
        for (n = 0; n < 10; n++) begin
            send_item(chans[n], vals[n]);
        end
    endtask

    // Order zero and orders above four, gain beyond one, extreme feedback, and writes
    // to addresses past the register list.
    task automatic test_order_bounds();
        apply_filter(3'd0, 29'h1000_0000, -32'sh0800_0000, 32'sh7FFF_FFFF, 32'sd1, -32'sd1);
        send_item(5'd0, 32'h0001_0000);
        send_item(5'd1, 32'hFFF0_0000);
        apply_filter(3'd5, 29'h1FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000,
                     32'sh7FFF_FFFF, -32'sh8000_0000);
        send_item(5'd2, 32'h0000_0100);
        send_item(5'd0, 32'h7FFF_FFFF);
        send_item(5'd31, 32'h8000_0000);
        apply_filter(3'd7, 29'd0, -32'sh8000_0000, -32'sh8000_0000,
                     -32'sh8000_0000, -32'sh8000_0000);
        send_item(5'd1, 32'h0000_0001);
        send_item(5'd2, 32'hFFFF_FFFF);
        apply_filter(3'd6, 29'h1000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_item(5'd3, 32'h1234_5678);
        wait_drained();
        write_reg(REG_SPARE_LOW, $urandom());
        write_reg(REG_SPARE_HIGH, $urandom());
        verify_registers();
        send_item(5'd3, 32'hEDCB_A988);
        send_item(5'd0, 32'h0000_8000);
    endtask

    // Real low-pass filters of every order and three pole positions. One setting runs
    // with no idling on either side, and each setting pauses once to drain.
    task automatic test_lowpass_sweep();
        int shift;
        int order;
        for (shift = 1; shift <= 3; shift++) begin
            for (order = int'(miir_pkg::ORDER_MIN); order <= int'(miir_pkg::ORDER_MAX);
                 order++) begin
                apply_pole_filter(order, shift);
                quiet = (shift == 2 && order == int'(miir_pkg::ORDER_MAX));
                run_items(80, int'($urandom_range(79)));
            end
        end
        wait_drained();
        quiet = 1'b0;
    endtask

    // Arbitrary coefficients: outputs mostly saturate.
    task automatic test_random_coefficients();
        int n;
        for (n = 0; n < 8; n++) begin
            apply_filter(miir_pkg::ORDER_BITS'($urandom()), miir_pkg::GAIN_BITS'($urandom()),
                         $urandom(), $urandom(), $urandom(), $urandom());
            run_items(50, -1);
        end
    endtask

    task automatic test_coefficient_extremes();
        apply_filter(3'd4, 29'd0, -32'sh8000_0000, -32'sh8000_0000,
                     -32'sh8000_0000, -32'sh8000_0000);
        run_items(30, -1);
        apply_filter(3'd4, 29'h1FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        run_items(30, -1);
        apply_filter(3'd1, 29'h1FFF_FFFF, -32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0);
        run_items(30, -1);
        // No feedforward and a feedback of minus one: each channel holds its last output.
        apply_filter(3'd2, 29'd0, -32'sh1000_0000, 32'sd0, 32'sd0, 32'sd0);
        run_items(30, -1);
    endtask

    // Result side: stalls at random and checks every result it takes against the
    // oldest owed sample. Stall is driven and sampled at the same edge, so the value
    // read here is the one the block saw.
    always @(posedge i_clk) begin : result_check
        t_filtered want;
        i_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outputs.size() == 0) begin
                note_failure($sformatf("unexpected result: ch %0d sample %0d",
                                       o_channel_out, o_sample_out));
            end else begin
                want = pending_outputs.pop_front();
                if (want.channel !== o_channel_out || want.sample !== o_sample_out) begin
                    note_failure($sformatf(
                        "mismatch: expected ch %0d sample %0d, got ch %0d sample %0d",
                        want.channel, $signed(want.sample), o_channel_out, o_sample_out));
                end
            end
        end
    end

    // The regression: reset held low, then each test in turn, then a final drain and
    // the verdict.
    initial begin : regression
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_defaults();
        test_directed_samples();
        test_order_bounds();
        test_lowpass_sweep();
        test_random_coefficients();
        test_coefficient_extremes();
        wait_drained();
        if (fail_count == 0 && pending_outputs.size() == 0) begin
            $display("multichannel_iir_lowpass regression: pass");
        end else begin
            $display("multichannel_iir_lowpass regression: fail");
        end
        $finish;
    end

    // Ends a run that hangs, for example on a block that never returns a result.
    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("multichannel_iir_lowpass regression: fail");
        $finish;
    end

endmodule
